@@ design/csm_pkg.sv @@
// Package for the channel grid slot mapper: constants, codes and shared types.
// Used by every module in the design folder.
package csm_pkg;

  // Grid bounds
  localparam logic [16:0] MAX_SLOTS          = 17'd4096;
  localparam logic [31:0] MIN_FREQ_MHZ       = 32'd184000000;
  localparam logic [31:0] MAX_FREQ_MHZ       = 32'd200000000;
  localparam logic [19:0] MIN_SLOT_WIDTH_MHZ = 20'd3125;
  localparam logic [19:0] MAX_SLOT_WIDTH_MHZ = 20'd100000;

  // Grid kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_FIXED   = 2'd1;
  localparam logic [1:0] KIND_FLEX    = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // Request codes
  localparam logic [1:0] REQ_S2F   = 2'd0;
  localparam logic [1:0] REQ_F2S   = 2'd1;
  localparam logic [1:0] REQ_WIDTH = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_KIND   = 3'd0;
  localparam logic [2:0] CFG_ANCHOR = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SLOTS  = 3'd3;
  localparam logic [2:0] CFG_MINCH  = 3'd4;
  localparam logic [2:0] CFG_MAXCH  = 3'd5;

  // Divider sizing: quotient bits and numerator bits
  localparam int QBITS = 13;
  localparam int NBITS = 25;

  typedef struct packed {
    logic [1:0]  grid_kind;
    logic [31:0] anchor_mhz;
    logic [19:0] slot_width_mhz;
    logic [12:0] grid_slots;
    logic [7:0]  min_channel_slots;
    logic [7:0]  max_channel_slots;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  req;
    logic [31:0] low_mhz;
    logic [31:0] high_mhz;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [NBITS-1:0] r_lo;
    logic [NBITS-1:0] r_hi;
    logic [QBITS-1:0] q_lo;
    logic [QBITS-1:0] q_hi;
  } div_t;

endpackage

@@ design/channel_grid_slot_mapper.sv @@
// Channel grid slot mapper: slot/frequency conversion on an equal-width grid.
// Path: input register, front register, divider input register, divider stages, output register.
// Throughput: one item per cycle; the whole pipeline holds when the output stalls.
// The 13-stage pipelined divider sets the depth.
// Reset: synchronous rst empties the pipeline and loads the default grid registers.
// Depends on csm_pkg, csm_front and csm_div.
module channel_grid_slot_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] first_slot_in,
  input  logic [15:0] slot_count_in,
  input  logic [31:0] low_mhz_in,
  input  logic [31:0] high_mhz_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] low_mhz_out,
  output logic [31:0] high_mhz_out,
  output logic [11:0] first_slot_out,
  output logic [12:0] slot_count_out
);
  import csm_pkg::*;

  cfg_t        cfg;
  logic        en;
  logic        div_valid;
  div_t        div_in;
  logic        res_valid;
  div_t        res;
  logic        ok1;
  logic [12:0] cnt;
  logic        ok_next;
  logic [11:0] first_slot_next;
  logic [12:0] slot_count_next;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_kind         <= KIND_UNKNOWN;
      cfg.anchor_mhz        <= 32'd0;
      cfg.slot_width_mhz    <= 20'd12500;
      cfg.grid_slots        <= 13'd0;
      cfg.min_channel_slots <= 8'd1;
      cfg.max_channel_slots <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KIND:   cfg.grid_kind         <= cfg_data[1:0];
        CFG_ANCHOR: cfg.anchor_mhz        <= cfg_data;
        CFG_WIDTH:  cfg.slot_width_mhz    <= cfg_data[19:0];
        CFG_SLOTS:  cfg.grid_slots        <= cfg_data[12:0];
        CFG_MINCH:  cfg.min_channel_slots <= cfg_data[7:0];
        CFG_MAXCH:  cfg.max_channel_slots <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  csm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .req_type     (req_type),
    .first_slot_in(first_slot_in),
    .slot_count_in(slot_count_in),
    .low_mhz_in   (low_mhz_in),
    .high_mhz_in  (high_mhz_in),
    .cfg          (cfg),
    .div_valid    (div_valid),
    .div_in       (div_in)
  );

  csm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .divisor  (cfg.slot_width_mhz),
    .div_valid(div_valid),
    .div_in   (div_in),
    .res_valid(res_valid),
    .res      (res)
  );

  // covering end must pass the first slot and stay inside the grid
  always_comb begin
    ok1 = (res.q_hi > res.q_lo) && (res.q_hi <= cfg.grid_slots);
    cnt = res.q_hi - res.q_lo;
    ok_next         = res.meta.ok;
    first_slot_next = 12'd0;
    slot_count_next = 13'd0;
    if (res.meta.req == REQ_F2S) begin
      ok_next = res.meta.ok && ok1;
      if (res.meta.ok && ok1) begin
        first_slot_next = res.q_lo[11:0];
        slot_count_next = cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      low_mhz_out    <= res.meta.low_mhz;
      high_mhz_out   <= res.meta.high_mhz;
      first_slot_out <= first_slot_next;
      slot_count_out <= slot_count_next;
      ok             <= ok_next;
    end
  end

endmodule

@@ design/csm_front.sv @@
// Front stages: input register, products and differences, then grid checks.
// Depends on csm_pkg.
module csm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  input  logic [15:0]         first_slot_in,
  input  logic [15:0]         slot_count_in,
  input  logic [31:0]         low_mhz_in,
  input  logic [31:0]         high_mhz_in,
  input  csm_pkg::cfg_t       cfg,
  output logic                div_valid,
  output csm_pkg::div_t       div_in
);
  import csm_pkg::*;

  // stage 1
  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [15:0] s1_first;
  logic [15:0] s1_count;
  logic [31:0] s1_lo;
  logic [31:0] s1_hi;

  // stage 2
  logic        s2_valid;
  logic [1:0]  s2_req;
  logic        s2_cnt_ok;
  logic        s2_base_ok;
  logic        s2_hi_gt;
  logic        s2_lo_ge;
  logic        s2_sup;
  logic [31:0] s2_p_lo;
  logic [31:0] s2_p_hi;
  logic [32:0] s2_span;
  logic [31:0] s2_hi;
  logic [NBITS-1:0] s2_n_lo;
  logic [NBITS-1:0] s2_n_hi;

  logic [16:0] sum_fc;
  logic [35:0] p_lo_full;
  logic [36:0] p_hi_full;
  logic [32:0] n_hi_full;
  logic [32:0] n_lo_full;
  logic        sup;
  logic [33:0] grid_end;
  logic        grid_ok;
  logic        ok0;
  logic        ok1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    sum_fc    = 17'(s1_first) + 17'(s1_count);
    p_lo_full = 36'(s1_first) * 36'(cfg.slot_width_mhz);
    p_hi_full = 37'(sum_fc) * 37'(cfg.slot_width_mhz);
    n_lo_full = {1'b0, s1_lo} - {1'b0, cfg.anchor_mhz};
    n_hi_full = {1'b0, s1_hi} - {1'b0, cfg.anchor_mhz} + 33'(cfg.slot_width_mhz) - 33'd1;
    sup = 1'b0;
    if (s1_count != 16'd0) begin
      if (cfg.grid_kind == KIND_FIXED) begin
        sup = (s1_count == 16'd1);
      end else if (cfg.grid_kind == KIND_FLEX) begin
        sup = (s1_count >= 16'(cfg.min_channel_slots)) &&
              (s1_count <= 16'(cfg.max_channel_slots));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req   <= req_type;
      s1_first <= first_slot_in;
      s1_count <= slot_count_in;
      s1_lo    <= low_mhz_in;
      s1_hi    <= high_mhz_in;

      s2_req     <= s1_req;
      s2_cnt_ok  <= (s1_count != 16'd0) && (17'(s1_count) <= MAX_SLOTS) &&
                    (sum_fc <= 17'(cfg.grid_slots));
      s2_base_ok <= ((cfg.grid_kind == KIND_FIXED) || (cfg.grid_kind == KIND_FLEX)) &&
                    (cfg.anchor_mhz >= MIN_FREQ_MHZ) && (cfg.anchor_mhz <= MAX_FREQ_MHZ) &&
                    (cfg.slot_width_mhz >= MIN_SLOT_WIDTH_MHZ) &&
                    (cfg.slot_width_mhz <= MAX_SLOT_WIDTH_MHZ) &&
                    (cfg.grid_slots != 13'd0) && (17'(cfg.grid_slots) <= MAX_SLOTS);
      s2_hi_gt   <= s1_hi > s1_lo;
      s2_lo_ge   <= s1_lo >= cfg.anchor_mhz;
      s2_sup     <= sup;
      s2_p_lo    <= p_lo_full[31:0];
      s2_p_hi    <= p_hi_full[31:0];
      s2_span    <= 33'(cfg.grid_slots) * 33'(cfg.slot_width_mhz);
      s2_hi      <= s1_hi;
      s2_n_lo    <= n_lo_full[NBITS-1:0];
      s2_n_hi    <= n_hi_full[NBITS-1:0];
    end
  end

  always_comb begin
    grid_end = 34'(cfg.anchor_mhz) + 34'(s2_span);
    grid_ok  = s2_base_ok && (grid_end <= 34'(MAX_FREQ_MHZ));
    ok0 = (s2_req == REQ_S2F) && s2_cnt_ok && grid_ok;
    ok1 = (s2_req == REQ_F2S) && s2_hi_gt && grid_ok && s2_lo_ge &&
          (34'(s2_hi) <= grid_end);
    div_valid            = s2_valid;
    div_in.meta.ok       = ok0 || ok1 || ((s2_req == REQ_WIDTH) && s2_sup);
    div_in.meta.req      = s2_req;
    div_in.meta.low_mhz  = ok0 ? (cfg.anchor_mhz + s2_p_lo) : 32'd0;
    div_in.meta.high_mhz = ok0 ? (cfg.anchor_mhz + s2_p_hi) : 32'd0;
    div_in.r_lo          = s2_n_lo;
    div_in.r_hi          = s2_n_hi;
    div_in.q_lo          = '0;
    div_in.q_hi          = '0;
  end

endmodule

@@ design/csm_div.sv @@
// Pipelined restoring divider: floor and ceiling slot quotients, one bit a stage.
// Depends on csm_pkg.
module csm_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [19:0]         divisor,
  input  logic                div_valid,
  input  csm_pkg::div_t       div_in,
  output logic                res_valid,
  output csm_pkg::div_t       res
);
  import csm_pkg::*;

  logic  st_valid [QBITS+1];
  div_t  st       [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_in;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [32:0] dsh;
    logic        ge_lo;
    logic        ge_hi;
    div_t        nxt;

    always_comb begin
      // divisor weighted by the quotient bit this stage decides
      dsh   = 33'(divisor) << (QBITS - 1 - k);
      ge_lo = 33'(st[k].r_lo) >= dsh;
      ge_hi = 33'(st[k].r_hi) >= dsh;
      nxt      = st[k];
      nxt.r_lo = ge_lo ? (st[k].r_lo - dsh[NBITS-1:0]) : st[k].r_lo;
      nxt.r_hi = ge_hi ? (st[k].r_hi - dsh[NBITS-1:0]) : st[k].r_hi;
      nxt.q_lo = {st[k].q_lo[QBITS-2:0], ge_lo};
      nxt.q_hi = {st[k].q_hi[QBITS-2:0], ge_hi};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign res_valid = st_valid[QBITS];
  assign res       = st[QBITS];

endmodule
